// ===== src/assert_macros.svh =====
// Shared assertion forms for the checkers of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define EG_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("eg assertion failed");

// Checked at every rising edge, reset included.
`define EG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("eg assertion failed");

`endif

// ===== src/eg_pkg.sv =====
`timescale 1ns / 1ps
package eg_pkg;

  localparam int FW                = 31;
  localparam int MODULUS_BITS_DEF  = 31;
  localparam int Q_DEPTH           = 2;
  localparam int CNT_W             = $clog2(FW + 1);
  localparam int IDX_W             = 2;

  localparam logic [IDX_W-1:0] REG_MODULUS     = 2'd0;
  localparam logic [IDX_W-1:0] REG_GENERATOR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRIVATE_KEY = 2'd2;

  localparam logic [FW-1:0] MODULUS_RST = 31'h7fffffff;
  localparam logic [FW-1:0] GEN_RST     = 31'd7;
  localparam logic [FW-1:0] KEY_RST     = 31'd1;

  typedef enum logic [1:0] {
    K_ENC,
    K_DEC,
    K_DEGEN
  } item_kind_t;

  typedef struct packed {
    item_kind_t      kind;
    logic            cmd;
    logic [FW-1:0]   message;
    logic [FW-1:0]   ephemeral;
    logic [FW-1:0]   c1;
    logic [FW-1:0]   c2;
  } item_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } arith_op_t;

  typedef struct packed {
    logic          start;
    arith_op_t     op;
    logic [FW-1:0] a;
    logic [FW-1:0] b;
  } arith_req_t;

  typedef struct packed {
    logic          done;
    logic [FW-1:0] res;
    logic [FW-1:0] quo;
  } arith_rsp_t;

  typedef enum logic [1:0] {
    PH_YA,
    PH_K,
    PH_C1
  } pow_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POW_RED,
    ST_POW_LOOP,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_MSG_RED,
    ST_C2_MUL,
    ST_C2_RED,
    ST_EU_CHK,
    ST_EU_DIV,
    ST_EU_MUL,
    ST_DEC_MUL,
    ST_DONE
  } back_state_t;

endpackage

// ===== src/eg_if.sv =====
`timescale 1ns / 1ps
interface eg_in_if import eg_pkg::*; ();
  logic          valid;
  logic          ready;
  logic          cmd;
  logic [FW-1:0] message;
  logic [FW-1:0] ephemeral;
  logic [FW-1:0] cipher_in_first;
  logic [FW-1:0] cipher_in_second;

  modport source (output valid, cmd, message, ephemeral, cipher_in_first,
                  cipher_in_second, input ready);
  modport sink (input valid, cmd, message, ephemeral, cipher_in_first,
                cipher_in_second, output ready);
endinterface

interface eg_out_if import eg_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [FW-1:0] public_key;
  logic [FW-1:0] shared_key;
  logic [FW-1:0] cipher_out_first;
  logic [FW-1:0] cipher_out_second;
  logic [FW-1:0] plaintext;
  logic          no_inverse;

  modport source (output valid, public_key, shared_key, cipher_out_first,
                  cipher_out_second, plaintext, no_inverse, input ready);
  modport sink (input valid, public_key, shared_key, cipher_out_first,
                cipher_out_second, plaintext, no_inverse, output ready);
endinterface

interface eg_cfg_if import eg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [FW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/elgamal_encrypt_decrypt_core.sv =====
`timescale 1ns / 1ps
// Sequence: an encrypt runs three exponentiations, a reduce and a multiply; a decrypt
//   runs two exponentiations, a reduce, Euclid and a multiply.
// Throughput: one item at a time, paced by the shared bit-serial modular unit
//   on every multiply or divide. A two-item queue takes items meanwhile.
// Reset (rst, synchronous): clears queue, sequencer and output valid; modulus,
//   generator and private key return to 2^31-1, 7 and 1.
module elgamal_encrypt_decrypt_core import eg_pkg::*; #(
  parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  eg_cfg_if.sink   cfg,
  eg_in_if.sink    item_in,
  eg_out_if.source result_out
);

  // configuration registers; the modulus keeps only its low bits
  logic [MODULUS_BITS-1:0] modulus;
  logic [FW-1:0]           generator;
  logic [FW-1:0]           private_key;
  logic [FW-1:0]           p;

  logic       head_valid;
  item_t      head;
  logic       pop;
  arith_req_t req;
  arith_rsp_t rsp;

  assign cfg.ready = 1'b1;
  assign p         = FW'(modulus);

  // take a write whenever offered; unknown indexes drop silently
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= MODULUS_BITS'(MODULUS_RST);
      generator   <= GEN_RST;
      private_key <= KEY_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODULUS:     modulus     <= cfg.data[MODULUS_BITS-1:0];
        REG_GENERATOR:   generator   <= cfg.data;
        REG_PRIVATE_KEY: private_key <= cfg.data;
        default: ;
      endcase
    end
  end

  // front: accept, classify and hold items
  eg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .p          (p),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // shared modular multiply / divide unit
  eg_arith u_arith (
    .clk (clk),
    .rst (rst),
    .p   (p),
    .req (req),
    .rsp (rsp)
  );

  // back: sequence exponentiations, inverse and the result register
  eg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .p          (p),
    .gen        (generator),
    .xa         (private_key),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .req        (req),
    .rsp        (rsp),
    .result_out (result_out)
  );

endmodule

// ===== src/eg_front.sv =====
`timescale 1ns / 1ps
module eg_front import eg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  eg_in_if.sink         item_in,
  input  logic [FW-1:0] p,
  input  logic          pop,
  output logic          head_valid,
  output item_t         head
);

  localparam int PW = $clog2(Q_DEPTH);

  item_t            entries [Q_DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [PW:0]      count;
  logic             push;
  logic             take;
  item_t            incoming;

  assign item_in.ready = (count < (PW+1)'(Q_DEPTH));
  assign push          = item_in.valid && item_in.ready;
  assign head_valid    = (count != '0);
  assign take          = pop && head_valid;
  assign head          = entries[rptr];

  // classify: a modulus below two gives a fixed result
  always_comb begin
    incoming.cmd       = item_in.cmd;
    incoming.message   = item_in.message;
    incoming.ephemeral = item_in.ephemeral;
    incoming.c1        = item_in.cipher_in_first;
    incoming.c2        = item_in.cipher_in_second;
    if (p < FW'(2)) begin
      incoming.kind = K_DEGEN;
    end else if (item_in.cmd) begin
      incoming.kind = K_DEC;
    end else begin
      incoming.kind = K_ENC;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (take) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(take);
    end
  end

endmodule

// ===== src/eg_arith.sv =====
`timescale 1ns / 1ps
module eg_arith import eg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [FW-1:0] p,
  input  arith_req_t    req,
  output arith_rsp_t    rsp
);

  logic             busy;
  logic             done;
  arith_op_t        op_r;
  logic [FW-1:0]    a_r;
  logic [FW-1:0]    b_r;
  logic [FW-1:0]    acc;
  logic [FW-1:0]    quo;
  logic [CNT_W-1:0] cnt;

  logic [FW:0] dbl;
  logic [FW:0] dbl_red;
  logic [FW:0] sum;
  logic [FW:0] sum_red;
  logic [FW:0] shl;
  logic        ge;

  // multiply: double and add, one bit of b per step, MSB first
  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
    sum     = dbl_red + (b_r[FW-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
  end

  // divide: restoring, one quotient bit per step
  always_comb begin
    shl = {acc, a_r[FW-1]};
    ge  = (shl >= {1'b0, b_r});
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op_r <= req.op;
      a_r  <= req.a;
      b_r  <= req.b;
      acc  <= '0;
      quo  <= '0;
    end else if (busy) begin
      if (op_r == OP_MUL) begin
        acc <= sum_red[FW-1:0];
        b_r <= {b_r[FW-2:0], 1'b0};
      end else begin
        acc <= ge ? FW'(shl - {1'b0, b_r}) : shl[FW-1:0];
        quo <= {quo[FW-2:0], ge};
        a_r <= {a_r[FW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = acc;
  assign rsp.quo  = quo;

endmodule

// ===== src/eg_back.sv =====
`timescale 1ns / 1ps
module eg_back import eg_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic [FW-1:0] p,
  input  logic [FW-1:0] gen,
  input  logic [FW-1:0] xa,
  input  logic          head_valid,
  input  item_t         head,
  output logic          pop,
  output arith_req_t    req,
  input  arith_rsp_t    rsp,
  eg_out_if.source      result_out
);

  back_state_t   state;
  back_state_t   state_next;
  pow_phase_t    phase;
  item_t         cur;
  logic          pending;
  logic          uses_unit;

  logic [FW-1:0] base;
  logic [FW-1:0] ex;
  logic [FW-1:0] acc;
  logic [FW-1:0] bb;
  logic [FW-1:0] ya;
  logic [FW-1:0] k;
  logic [FW-1:0] c1o;
  logic [FW-1:0] c2o;
  logic [FW-1:0] pt;
  logic          ni;
  logic [FW-1:0] red;
  logic [FW-1:0] er;
  logic [FW-1:0] enr;
  logic [FW-1:0] et;
  logic [FW-1:0] ent;
  logic [FW-1:0] q;
  logic [FW-1:0] rem;

  logic          o_valid;
  logic          o_load;
  logic [FW:0]   diff;
  logic [FW-1:0] qq;

  assign o_load = (state == ST_DONE) && (!o_valid || result_out.ready);
  assign pop    = (state == ST_IDLE) && head_valid;
  assign qq     = (q == p) ? '0 : q;
  assign diff   = (et >= rsp.res) ? {1'b0, et} - {1'b0, rsp.res}
                                  : {1'b0, et} + {1'b0, p} - {1'b0, rsp.res};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          state_next = (head.kind == K_DEGEN) ? ST_DONE : ST_POW_RED;
        end
      end
      ST_POW_RED: if (rsp.done) state_next = ST_POW_LOOP;
      ST_POW_LOOP: begin
        if (ex != '0) begin
          state_next = ex[0] ? ST_POW_MUL : ST_POW_SQR;
        end else begin
          case (phase)
            PH_YA:   state_next = ST_POW_RED;
            PH_K:    state_next = (cur.kind == K_ENC) ? ST_POW_RED : ST_C2_RED;
            PH_C1:   state_next = ST_MSG_RED;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_POW_MUL: if (rsp.done) state_next = ST_POW_SQR;
      ST_POW_SQR: if (rsp.done) state_next = ST_POW_LOOP;
      ST_MSG_RED: if (rsp.done) state_next = ST_C2_MUL;
      ST_C2_MUL:  if (rsp.done) state_next = ST_DONE;
      ST_C2_RED:  if (rsp.done) state_next = ST_EU_CHK;
      ST_EU_CHK: begin
        if (enr != '0) begin
          state_next = ST_EU_DIV;
        end else begin
          state_next = (er == FW'(1)) ? ST_DEC_MUL : ST_DONE;
        end
      end
      ST_EU_DIV:  if (rsp.done) state_next = ST_EU_MUL;
      ST_EU_MUL:  if (rsp.done) state_next = ST_EU_CHK;
      ST_DEC_MUL: if (rsp.done) state_next = ST_DONE;
      ST_DONE:    if (o_load) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    uses_unit = 1'b1;
    req.op    = OP_MUL;
    req.a     = '0;
    req.b     = '0;
    case (state)
      ST_POW_RED: begin
        req.op = OP_DIV;
        req.a  = base;
        req.b  = p;
      end
      ST_POW_MUL: begin
        req.a = acc;
        req.b = bb;
      end
      ST_POW_SQR: begin
        req.a = bb;
        req.b = bb;
      end
      ST_MSG_RED: begin
        req.op = OP_DIV;
        req.a  = cur.message;
        req.b  = p;
      end
      ST_C2_MUL: begin
        req.a = k;
        req.b = red;
      end
      ST_C2_RED: begin
        req.op = OP_DIV;
        req.a  = cur.c2;
        req.b  = p;
      end
      ST_EU_DIV: begin
        req.op = OP_DIV;
        req.a  = er;
        req.b  = enr;
      end
      ST_EU_MUL: begin
        req.a = qq;
        req.b = ent;
      end
      ST_DEC_MUL: begin
        req.a = red;
        req.b = et;
      end
      default: uses_unit = 1'b0;
    endcase
    req.start = uses_unit && !pending && !rsp.done;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.done) begin
        pending <= 1'b0;
      end else if (req.start) begin
        pending <= 1'b1;
      end
      if (o_load) begin
        o_valid <= 1'b1;
      end else if (result_out.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          cur   <= head;
          ya    <= '0;
          k     <= '0;
          c1o   <= '0;
          c2o   <= '0;
          pt    <= '0;
          ni    <= (head.kind == K_DEGEN) && head.cmd;
          phase <= PH_YA;
          base  <= gen;
          ex    <= xa;
        end
      end
      ST_POW_RED: begin
        if (rsp.done) begin
          bb  <= rsp.res;
          acc <= FW'(1);
        end
      end
      ST_POW_LOOP: begin
        if (ex == '0) begin
          case (phase)
            PH_YA: begin
              ya    <= acc;
              phase <= PH_K;
              base  <= (cur.kind == K_ENC) ? acc : cur.c1;
              ex    <= (cur.kind == K_ENC) ? cur.ephemeral : xa;
            end
            PH_K: begin
              k     <= acc;
              phase <= PH_C1;
              base  <= gen;
              ex    <= cur.ephemeral;
            end
            PH_C1:   c1o <= acc;
            default: ;
          endcase
        end
      end
      ST_POW_MUL: if (rsp.done) acc <= rsp.res;
      ST_POW_SQR: begin
        if (rsp.done) begin
          bb <= rsp.res;
          ex <= {1'b0, ex[FW-1:1]};
        end
      end
      ST_MSG_RED: if (rsp.done) red <= rsp.res;
      ST_C2_MUL:  if (rsp.done) c2o <= rsp.res;
      ST_C2_RED: begin
        if (rsp.done) begin
          red <= rsp.res;
          er  <= p;
          enr <= k;
          et  <= '0;
          ent <= FW'(1);
        end
      end
      ST_EU_CHK: begin
        if (enr == '0 && er != FW'(1)) begin
          ni <= 1'b1;
          pt <= (red == '0) ? '0 : p - red;
        end
      end
      ST_EU_DIV: begin
        if (rsp.done) begin
          q   <= rsp.quo;
          rem <= rsp.res;
        end
      end
      ST_EU_MUL: begin
        if (rsp.done) begin
          et  <= ent;
          ent <= diff[FW-1:0];
          er  <= enr;
          enr <= rem;
        end
      end
      ST_DEC_MUL: if (rsp.done) pt <= rsp.res;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      result_out.public_key        <= ya;
      result_out.shared_key        <= k;
      result_out.cipher_out_first  <= c1o;
      result_out.cipher_out_second <= c2o;
      result_out.plaintext         <= pt;
      result_out.no_inverse        <= ni;
    end
  end

  assign result_out.valid = o_valid;

endmodule

// ===== src/eg_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module eg_checker import eg_pkg::*; (
  input logic          clk,
  input logic          rst,
  input logic          cfg_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [FW-1:0] out_c1,
  input logic [FW-1:0] out_c2,
  input logic [FW-1:0] out_pt,
  input logic          out_ni
);

  `EG_ASSERT_ALWAYS(a_no_result_after_reset, clk, $past(rst) |-> !out_valid)
  `EG_ASSERT(a_result_held, clk, rst, out_valid && !out_ready |=> out_valid)
  `EG_ASSERT(a_cfg_always_ready, clk, rst, cfg_ready)
  `EG_ASSERT(a_decrypt_zeros, clk, rst, out_valid && out_ni |-> out_c1 == '0 && out_c2 == '0)
  `EG_ASSERT(a_encrypt_zeros, clk, rst, out_valid && out_pt != '0 |-> out_c1 == '0)

endmodule

bind elgamal_encrypt_decrypt_core eg_checker u_eg_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_c1    (result_out.cipher_out_first),
  .out_c2    (result_out.cipher_out_second),
  .out_pt    (result_out.plaintext),
  .out_ni    (result_out.no_inverse)
);

// ===== sim/tb_elgamal_encrypt_decrypt_core.sv =====
`timescale 1ns / 1ps
module tb_elgamal_encrypt_decrypt_core;
  import eg_pkg::*;

  localparam int MAX_WAIT = 13;
  localparam int DRAIN_CYCLES = 7000;

  // One result of the engine, in the order of the output fields
  typedef struct packed {
    logic [FW-1:0] public_key;
    logic [FW-1:0] shared_key;
    logic [FW-1:0] cipher_out_first;
    logic [FW-1:0] cipher_out_second;
    logic [FW-1:0] plaintext;
    logic          no_inverse;
  } elg_result_t;

  // Directed stimulus row; use_fixed marks rows whose outcome is typed in
  typedef struct {
    logic          cmd;
    logic [FW-1:0] message;
    logic [FW-1:0] ephemeral;
    logic [FW-1:0] c1;
    logic [FW-1:0] c2;
    bit            use_fixed;
    elg_result_t   fixed;
  } elg_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  eg_cfg_if cfg ();
  eg_in_if item_in ();
  eg_out_if result_out ();

  elgamal_encrypt_decrypt_core uut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg.sink),
    .item_in(item_in.sink),
    .result_out(result_out.source)
  );

  always #4 clk = ~clk;

  // Own copy of the configuration registers
  logic [FW-1:0] prime_p = MODULUS_RST;
  logic [FW-1:0] base_g = GEN_RST;
  logic [FW-1:0] secret_x = KEY_RST;

  elg_result_t pending_results[$];
  int mismatch_count = 0;
  int orphan_count = 0;
  bit hold_off_sink = 1'b0;
  int hold_off_len = 0;

  function automatic logic [62:0] mod_mul(logic [62:0] a, logic [62:0] b, logic [62:0] p);
    logic [63:0] prod;
    prod = a * b;
    return 63'(prod % p);
  endfunction

  function automatic logic [62:0] mod_pow(logic [62:0] x, logic [62:0] e, logic [62:0] p);
    logic [62:0] acc;
    logic [62:0] sq;
    acc = 1;
    sq = x % p;
    if (e == 0) return 1;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, sq, p);
      sq = mod_mul(sq, sq, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  // Extended Euclid; returns 0 when no inverse exists
  function automatic bit mod_inverse(logic [62:0] a, logic [62:0] p, output logic [62:0] inv);
    longint t, nt, r, nr, q, tmp;
    t = 0; nt = 1; r = p; nr = a % p;
    inv = 0;
    while (nr != 0) begin
      q = r / nr;
      tmp = t - q * nt; t = nt; nt = tmp;
      tmp = r - q * nr; r = nr; nr = tmp;
    end
    if (r != 1) return 1'b0;
    if (t < 0) t += longint'(p);
    inv = 63'(t);
    return 1'b1;
  endfunction

  function automatic elg_result_t elgamal_predict(logic cmd, logic [FW-1:0] msg,
                                                  logic [FW-1:0] r, logic [FW-1:0] c1,
                                                  logic [FW-1:0] c2);
    elg_result_t res;
    logic [62:0] p, ya, k, inv;
    res = '0;
    p = prime_p;
    if (p < 2) begin
      res.no_inverse = cmd;
      return res;
    end
    ya = mod_pow(base_g, secret_x, p);
    res.public_key = FW'(ya);
    if (cmd == 1'b0) begin
      k = mod_pow(ya, r, p);
      res.shared_key = FW'(k);
      res.cipher_out_first = FW'(mod_pow(base_g, r, p));
      res.cipher_out_second = FW'(mod_mul(k, msg, p));
    end else begin
      k = mod_pow(c1, secret_x, p);
      res.shared_key = FW'(k);
      if (mod_inverse(k, p, inv)) begin
        res.plaintext = FW'(mod_mul(c2 % p, inv, p));
      end else begin
        res.plaintext = FW'((p - (c2 % p)) % p);
        res.no_inverse = 1'b1;
      end
    end
    return res;
  endfunction

  // Configuration write; only called while the engine is idle
  task automatic write_register(logic [IDX_W-1:0] idx, logic [FW-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      REG_MODULUS:     prime_p = value;
      REG_GENERATOR:   base_g = value;
      REG_PRIVATE_KEY: secret_x = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one item after a random gap and hold it until taken
  task automatic send_item(logic cmd, logic [FW-1:0] msg, logic [FW-1:0] r,
                           logic [FW-1:0] c1, logic [FW-1:0] c2,
                           bit use_fixed, elg_result_t fixed);
    int gap;
    gap = $urandom_range(0, MAX_WAIT);
    if ($urandom_range(0, 3) == 0) gap = 0;
    // Drop valid only across a real gap; back to back it stays high
    if (gap != 0) begin
      item_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_in.valid <= 1'b1;
    item_in.cmd <= cmd;
    item_in.message <= msg;
    item_in.ephemeral <= r;
    item_in.cipher_in_first <= c1;
    item_in.cipher_in_second <= c2;
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    // Queue the expectation at acceptance, under the settings in force
    pending_results.push_back(use_fixed ? fixed :
                              elgamal_predict(cmd, msg, r, c1, c2));
  endtask

  task automatic wait_idle();
    item_in.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_item();
    logic [FW-1:0] m, r, c1, c2;
    logic cmd;
    m = FW'($urandom); r = FW'($urandom); c1 = FW'($urandom); c2 = FW'($urandom);
    cmd = 1'($urandom_range(0, 1));
    // Mostly well-formed values below p, occasionally raw full-width noise
    if ($urandom_range(0, 4) != 0 && prime_p > 1) begin
      m = m % prime_p; c1 = c1 % prime_p; c2 = c2 % prime_p;
    end
    if (r == {FW{1'b1}}) r = r - 1;
    send_item(cmd, m, r, c1, c2, 1'b0, '0);
  endtask

  // Result side: random stalls, plus a long hold-off when requested
  initial begin
    int stall;
    result_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off_sink) begin
        result_out.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_sink = 1'b0;
      end
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
      repeat (stall) @(posedge clk);
      result_out.ready <= 1'b1;
      @(posedge clk);
      while (!result_out.valid) @(posedge clk);
      result_out.ready <= 1'b0;
    end
  end

  // Compare each accepted result against the oldest expectation
  always @(posedge clk) begin
    elg_result_t got, want;
    if (!rst && result_out.valid && result_out.ready) begin
      got.public_key = result_out.public_key;
      got.shared_key = result_out.shared_key;
      got.cipher_out_first = result_out.cipher_out_first;
      got.cipher_out_second = result_out.cipher_out_second;
      got.plaintext = result_out.plaintext;
      got.no_inverse = result_out.no_inverse;
      if (pending_results.size() == 0) begin
        orphan_count++;
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    #400ms;
    $display("FAIL elgamal_encrypt_decrypt_core");
    $finish;
  end

  initial begin
    elg_row_t rows[$];
    elg_row_t row;
    elg_result_t zero_res;
    zero_res = '0;
    cfg.valid = 1'b0; cfg.index = REG_MODULUS; cfg.data = '0;
    item_in.valid = 1'b0; item_in.cmd = 1'b0; item_in.message = '0;
    item_in.ephemeral = '0; item_in.cipher_in_first = '0; item_in.cipher_in_second = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // After reset: p = 2^31-1, g = 7, Xa = 1, so Ya = 7.
    // Encrypt with r = 0: K = 1, C1 = 1, C2 = M.
    row = '{1'b0, 31'd12345, 31'd0, 31'd0, 31'd0, 1'b1,
            '{31'd7, 31'd1, 31'd1, 31'd12345, 31'd0, 1'b0}};
    rows.push_back(row);
    // Encrypt with r = 1 and M = p: C1 = 7, K = 7, C2 = 0.
    row = '{1'b0, 31'h7fffffff, 31'd1, 31'd0, 31'd0, 1'b1,
            '{31'd7, 31'd7, 31'd7, 31'd0, 31'd0, 1'b0}};
    rows.push_back(row);
    // Decrypt with C1 = 0: no inverse, plaintext = p - C2.
    row = '{1'b1, 31'd0, 31'd0, 31'd0, 31'd5, 1'b1,
            '{31'd7, 31'd0, 31'd0, 31'd0, 31'h7ffffffa, 1'b1}};
    rows.push_back(row);
    // Decrypt with C1 = p: K reduces to 0, C2 = p reduces to 0.
    row = '{1'b1, 31'd0, 31'd0, 31'h7fffffff, 31'h7fffffff, 1'b1,
            '{31'd7, 31'd0, 31'd0, 31'd0, 31'd0, 1'b1}};
    rows.push_back(row);
    // Decrypt with C1 = 1, unused message all ones, ephemeral 2^31-2: K = 1, M = C2.
    row = '{1'b1, 31'h7fffffff, 31'h7ffffffe, 31'd1, 31'd99, 1'b1,
            '{31'd7, 31'd1, 31'd0, 31'd0, 31'd99, 1'b0}};
    rows.push_back(row);
    // Extremes checked by the predictor
    row = '{1'b0, 31'h7ffffffe, 31'h7ffffffe, 31'h7fffffff, 31'h7fffffff, 1'b0, zero_res};
    rows.push_back(row);
    row = '{1'b1, 31'd0, 31'd0, 31'h7ffffffe, 31'h7ffffffe, 1'b0, zero_res};
    rows.push_back(row);
    row = '{1'b0, 31'h55555555, 31'h2aaaaaaa, 31'd0, 31'd0, 1'b0, zero_res};
    rows.push_back(row);
    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].message, rows[i].ephemeral, rows[i].c1,
                rows[i].c2, rows[i].use_fixed, rows[i].fixed);
    wait_idle();

    // Small prime, generator and key at extremes; includes Xa = 0
    write_register(REG_MODULUS, 31'd23);
    write_register(REG_GENERATOR, 31'd5);
    write_register(REG_PRIVATE_KEY, 31'd0);
    repeat (4) random_item();
    wait_idle();
    write_register(REG_PRIVATE_KEY, 31'd6);
    write_register(REG_GENERATOR, 31'h7fffffff);
    repeat (6) random_item();
    // Pile items up behind a long stall on the result side
    hold_off_len = 20000;
    hold_off_sink = 1'b1;
    repeat (6) random_item();
    wait_idle();

    // Composite modulus: factors shared with K give no inverse
    write_register(REG_MODULUS, 31'd15);
    write_register(REG_GENERATOR, 31'd3);
    send_item(1'b1, 31'd0, 31'd0, 31'd3, 31'd7, 1'b0, zero_res);
    send_item(1'b1, 31'd0, 31'd0, 31'd2, 31'd7, 1'b0, zero_res);
    repeat (5) random_item();
    wait_idle();

    // Degenerate moduli: all zero, no_inverse on decrypt
    write_register(REG_MODULUS, 31'd0);
    send_item(1'b0, 31'd1, 31'd1, 31'd1, 31'd1, 1'b1, zero_res);
    zero_res.no_inverse = 1'b1;
    send_item(1'b1, 31'd1, 31'd1, 31'd1, 31'd1, 1'b1, zero_res);
    wait_idle();
    write_register(REG_MODULUS, 31'd1);
    repeat (2) random_item();
    wait_idle();
    write_register(REG_MODULUS, 31'd2);
    repeat (3) random_item();
    wait_idle();

    // Large prime with full-width key, generator 7
    write_register(REG_MODULUS, 31'h7fffffff);
    write_register(REG_GENERATOR, 31'd7);
    write_register(REG_PRIVATE_KEY, 31'h7ffffffd);
    repeat (30) random_item();
    wait_idle();
    write_register(REG_MODULUS, 31'd65521);
    write_register(REG_PRIVATE_KEY, FW'($urandom_range(1, 65519)));
    repeat (30) random_item();
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS elgamal_encrypt_decrypt_core");
    end else begin
      $display("FAIL elgamal_encrypt_decrypt_core");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/eg_pkg.sv
src/eg_if.sv
src/eg_front.sv
src/eg_arith.sv
src/eg_back.sv
src/elgamal_encrypt_decrypt_core.sv
src/eg_checker.sv
sim/tb_elgamal_encrypt_decrypt_core.sv
